[design/flow_vector_to_rgb_quantizer_top_defines.svh]
// Assertion macros for the flow vector quantizer modules, included by fvq_skid.
`ifndef FLOW_VECTOR_TO_RGB_QUANTIZER_TOP_DEFINES_SVH
`define FLOW_VECTOR_TO_RGB_QUANTIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define FVQ_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fvq assertion failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define FVQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fvq assertion failed: next-cycle implication");

`endif

[design/fvq_pkg.sv]
// Types and constants of the flow vector to RGB quantizer.
package fvq_pkg;

   localparam int FLOW_WIDTH      = 16;
   localparam int BYTE_WIDTH      = 8;
   localparam int SQUARE_WIDTH    = 31;
   localparam int RADICAND_WIDTH  = 32;
   localparam int ROOT_WIDTH      = 16;
   localparam int MAG_WIDTH       = 17;
   localparam int VALUE_WIDTH     = 18;
   localparam int NUM_WIDTH       = 24;
   localparam int DEN_WIDTH       = 16;
   localparam int DIV_STEPS       = 8;
   localparam int LANES           = 3;
   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOWER_BOUND = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_BOUND = 8'd1;

   localparam logic signed [FLOW_WIDTH-1:0] LOWER_BOUND_RESET = -16'sd3840;
   localparam logic signed [FLOW_WIDTH-1:0] UPPER_BOUND_RESET = 16'sd3840;

   localparam logic [BYTE_WIDTH-1:0] BYTE_MAX = 8'd255;

   typedef struct packed {
      logic signed [FLOW_WIDTH-1:0] flow_horizontal;
      logic signed [FLOW_WIDTH-1:0] flow_vertical;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] red_byte;
      logic [BYTE_WIDTH-1:0] green_byte;
      logic [BYTE_WIDTH-1:0] blue_byte;
   } rsp_payload_type;

endpackage

[design/fvq_sqrt.sv]
// Pipelined rounded square root of x*x + y*y, one root bit per stage.
module fvq_sqrt (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic [fvq_pkg::SQUARE_WIDTH-1:0]      in_square_x,
   input  logic [fvq_pkg::SQUARE_WIDTH-1:0]      in_square_y,
   input  fvq_pkg::req_payload_type              in_pair,
   output logic                                  out_valid,
   output logic [fvq_pkg::MAG_WIDTH-1:0]         out_root,
   output fvq_pkg::req_payload_type              out_pair
);
   import fvq_pkg::*;

   localparam int STEPS = ROOT_WIDTH;

   logic                      valid_ff [0:STEPS];
   logic [RADICAND_WIDTH-1:0] rem_ff   [0:STEPS];
   logic [ROOT_WIDTH-1:0]     root_ff  [0:STEPS];
   req_payload_type           pair_ff  [0:STEPS];

   logic                      round_valid_ff;
   logic [MAG_WIDTH-1:0]      round_root_ff;
   req_payload_type           round_pair_ff;

   // Stage zero forms the radicand.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= {1'b0, in_square_x} + {1'b0, in_square_y};
         root_ff[0] <= '0;
         pair_ff[0] <= in_pair;
      end
   end

   // Each stage decides one root bit, most significant first, and keeps
   // the remainder radicand - root*root.
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam int BIT = STEPS - k;
      logic [RADICAND_WIDTH:0] trial;
      logic                    take;

      always_comb begin
         trial = ({{(RADICAND_WIDTH + 1 - ROOT_WIDTH){1'b0}}, root_ff[k-1]} << (BIT + 1))
               + ((RADICAND_WIDTH + 1)'(1) << (2 * BIT));
         take  = {1'b0, rem_ff[k-1]} >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= take ? rem_ff[k-1] - trial[RADICAND_WIDTH-1:0] : rem_ff[k-1];
            root_ff[k] <= take ? root_ff[k-1] | (ROOT_WIDTH'(1) << BIT) : root_ff[k-1];
            pair_ff[k] <= pair_ff[k-1];
         end
      end
   end

   // Round to nearest: step up when the remainder exceeds the floor root.
   always_ff @(posedge clock) begin
      if (reset) begin
         round_valid_ff <= 1'b0;
      end else if (advance) begin
         round_valid_ff <= valid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (rem_ff[STEPS] > {{(RADICAND_WIDTH - ROOT_WIDTH){1'b0}}, root_ff[STEPS]}) begin
            round_root_ff <= {1'b0, root_ff[STEPS]} + MAG_WIDTH'(1);
         end else begin
            round_root_ff <= {1'b0, root_ff[STEPS]};
         end
         round_pair_ff <= pair_ff[STEPS];
      end
   end

   assign out_valid = round_valid_ff;
   assign out_root  = round_root_ff;
   assign out_pair  = round_pair_ff;

endmodule

[design/fvq_quant.sv]
// Three-lane clamp and round-half-even quantizer with a pipelined divider.
module fvq_quant (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic                                    in_valid,
   input  logic signed [fvq_pkg::VALUE_WIDTH-1:0]  in_value [0:fvq_pkg::LANES-1],
   input  logic signed [fvq_pkg::FLOW_WIDTH-1:0]   lower_bound,
   input  logic signed [fvq_pkg::FLOW_WIDTH-1:0]   upper_bound,
   output logic                                    out_valid,
   output logic [fvq_pkg::BYTE_WIDTH-1:0]          out_byte [0:fvq_pkg::LANES-1]
);
   import fvq_pkg::*;

   logic                   valid_ff  [0:DIV_STEPS];
   logic [DEN_WIDTH-1:0]   den_ff    [0:DIV_STEPS];
   logic [NUM_WIDTH-1:0]   rem_ff    [0:LANES-1][0:DIV_STEPS];
   logic [BYTE_WIDTH-1:0]  q_ff      [0:LANES-1][0:DIV_STEPS];
   logic                   sat_hi_ff [0:LANES-1][0:DIV_STEPS];
   logic                   sat_lo_ff [0:LANES-1][0:DIV_STEPS];

   logic                   out_valid_ff;
   logic [BYTE_WIDTH-1:0]  byte_ff   [0:LANES-1];

   logic signed [FLOW_WIDTH:0] span;
   logic                       bounds_empty;

   always_comb begin
      span         = {upper_bound[FLOW_WIDTH-1], upper_bound}
                   - {lower_bound[FLOW_WIDTH-1], lower_bound};
      bounds_empty = upper_bound <= lower_bound;
   end

   // The valid bit and divisor travel beside the lane data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff[0] <= span[DEN_WIDTH-1:0];
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [VALUE_WIDTH:0] diff;
      logic [DEN_WIDTH-1:0]        offset;
      logic [NUM_WIDTH:0]          twice_rem;
      logic                        round_up;
      logic [BYTE_WIDTH:0]         q_rounded;

      // Offset from the low bound, scaled by 255 as (d << 8) - d.
      always_comb begin
         diff   = {in_value[l][VALUE_WIDTH-1], in_value[l]}
                - (VALUE_WIDTH + 1)'(lower_bound);
         offset = diff[DEN_WIDTH-1:0];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[l][0]    <= {offset, {BYTE_WIDTH{1'b0}}}
                             - {{BYTE_WIDTH{1'b0}}, offset};
            q_ff[l][0]      <= '0;
            sat_hi_ff[l][0] <= in_value[l] > upper_bound;
            sat_lo_ff[l][0] <= bounds_empty || (in_value[l] < lower_bound);
         end
      end

      // Restoring division, one quotient bit per stage.
      for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
         localparam int BIT = DIV_STEPS - k;
         logic [NUM_WIDTH-1:0] shifted;
         logic                 take;

         always_comb begin
            shifted = {{(NUM_WIDTH - DEN_WIDTH){1'b0}}, den_ff[k-1]} << BIT;
            take    = rem_ff[l][k-1] >= shifted;
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[l][k]    <= take ? rem_ff[l][k-1] - shifted : rem_ff[l][k-1];
               q_ff[l][k]      <= take ? q_ff[l][k-1] | (BYTE_WIDTH'(1) << BIT)
                                       : q_ff[l][k-1];
               sat_hi_ff[l][k] <= sat_hi_ff[l][k-1];
               sat_lo_ff[l][k] <= sat_lo_ff[l][k-1];
            end
         end
      end

      // Round half to even, then apply the clamp flags.
      always_comb begin
         twice_rem = {rem_ff[l][DIV_STEPS], 1'b0};
         round_up  = (twice_rem > {{(NUM_WIDTH + 1 - DEN_WIDTH){1'b0}}, den_ff[DIV_STEPS]})
                  || ((twice_rem == {{(NUM_WIDTH + 1 - DEN_WIDTH){1'b0}}, den_ff[DIV_STEPS]})
                      && q_ff[l][DIV_STEPS][0]);
         q_rounded = {1'b0, q_ff[l][DIV_STEPS]} + (BYTE_WIDTH + 1)'(round_up);
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            if (sat_hi_ff[l][DIV_STEPS]) begin
               byte_ff[l] <= BYTE_MAX;
            end else if (sat_lo_ff[l][DIV_STEPS]) begin
               byte_ff[l] <= '0;
            end else if (q_rounded[BYTE_WIDTH]) begin
               byte_ff[l] <= BYTE_MAX;
            end else begin
               byte_ff[l] <= q_rounded[BYTE_WIDTH-1:0];
            end
         end
      end

      assign out_byte[l] = byte_ff[l];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[DIV_STEPS];
      end
   end

   assign out_valid = out_valid_ff;

endmodule

[design/fvq_skid.sv]
// Output register with a skid entry that decouples the pipeline from the stall.
module fvq_skid (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  fvq_pkg::rsp_payload_type  in_payload,
   output logic                      advance,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output fvq_pkg::rsp_payload_type  rsp_payload
);
   import fvq_pkg::*;

   `include "flow_vector_to_rgb_quantizer_top_defines.svh"

   logic            out_valid_ff;
   logic            skid_valid_ff;
   rsp_payload_type out_payload_ff;
   rsp_payload_type skid_payload_ff;
   logic            out_free;

   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      advance  = !skid_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_valid;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_payload_ff <= skid_valid_ff ? skid_payload_ff : in_payload;
      end else if (!skid_valid_ff) begin
         skid_payload_ff <= in_payload;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

   `FVQ_ASSERT_IMPLIES(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff)
   `FVQ_ASSERT_IMPLIES(a_skid_fill_on_stall, clock, reset, $rose(skid_valid_ff), $past(out_valid_ff && rsp_stall))
   `FVQ_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, !out_valid_ff && !skid_valid_ff)
   `FVQ_ASSERT_NEXT(a_skid_holds, clock, reset, out_valid_ff && rsp_stall && skid_valid_ff, skid_valid_ff)

endmodule

[design/flow_vector_to_rgb_quantizer_top.sv]
// Top level of the flow vector to RGB quantizer: bound registers and pipeline.
// Throughput: one transaction per cycle while the skid entry is empty, which is when
// advance is high; the 16-stage root and 8-stage divider are pipelined.
// The output register plus one skid entry keeps req_stall a registered signal.
// Reset (synchronous, active high) empties the pipeline and sets the bounds to -3840 and 3840.
module flow_vector_to_rgb_quantizer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  fvq_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output fvq_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fvq_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fvq_pkg::FLOW_WIDTH-1:0]       csr_data
);
   import fvq_pkg::*;

   // Bound registers. Writes are to come only while the pipeline is empty (the block does
   // not enforce it), so the quantizer reads them directly without per-transaction copies.
   logic signed [FLOW_WIDTH-1:0] lower_bound_ff;
   logic signed [FLOW_WIDTH-1:0] upper_bound_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_bound_ff <= LOWER_BOUND_RESET;
         upper_bound_ff <= UPPER_BOUND_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOWER_BOUND: lower_bound_ff <= $signed(csr_data);
            CSR_UPPER_BOUND: upper_bound_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // One pipeline enable for every stage. It drops only while the skid entry
   // is occupied, which is what stalls the request side as well.
   logic advance;

   assign req_stall = !advance;

   // Input stage: capture the transaction.
   logic            in_valid_ff;
   req_payload_type in_pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_pair_ff <= req_payload;
      end
   end

   // Square stage: the absolute values are 17 bits so that -32768 is exact;
   // each square stays below 2^31.
   logic signed [FLOW_WIDTH:0]   ext_x;
   logic signed [FLOW_WIDTH:0]   ext_y;
   logic [FLOW_WIDTH:0]          abs_x;
   logic [FLOW_WIDTH:0]          abs_y;
   logic [2*FLOW_WIDTH+1:0]      prod_x;
   logic [2*FLOW_WIDTH+1:0]      prod_y;

   logic                         sq_valid_ff;
   logic [SQUARE_WIDTH-1:0]      sq_x_ff;
   logic [SQUARE_WIDTH-1:0]      sq_y_ff;
   req_payload_type              sq_pair_ff;

   always_comb begin
      ext_x  = {in_pair_ff.flow_horizontal[FLOW_WIDTH-1], in_pair_ff.flow_horizontal};
      ext_y  = {in_pair_ff.flow_vertical[FLOW_WIDTH-1], in_pair_ff.flow_vertical};
      abs_x  = ext_x[FLOW_WIDTH] ? (FLOW_WIDTH + 1)'(-ext_x) : (FLOW_WIDTH + 1)'(ext_x);
      abs_y  = ext_y[FLOW_WIDTH] ? (FLOW_WIDTH + 1)'(-ext_y) : (FLOW_WIDTH + 1)'(ext_y);
      prod_x = abs_x * abs_x;
      prod_y = abs_y * abs_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_x_ff    <= prod_x[SQUARE_WIDTH-1:0];
         sq_y_ff    <= prod_y[SQUARE_WIDTH-1:0];
         sq_pair_ff <= in_pair_ff;
      end
   end

   // Magnitude: sum of squares and the rounded root, with x and y carried along.
   logic                  mag_valid;
   logic [MAG_WIDTH-1:0]  mag_root;
   req_payload_type       mag_pair;

   fvq_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (sq_valid_ff),
      .in_square_x (sq_x_ff),
      .in_square_y (sq_y_ff),
      .in_pair     (sq_pair_ff),
      .out_valid   (mag_valid),
      .out_root    (mag_root),
      .out_pair    (mag_pair)
   );

   // Quantize x, y and the magnitude in three parallel lanes.
   logic signed [VALUE_WIDTH-1:0] lane_value [0:LANES-1];
   logic [BYTE_WIDTH-1:0]         lane_byte  [0:LANES-1];
   logic                          quant_valid;
   rsp_payload_type               quant_payload;

   always_comb begin
      lane_value[0] = VALUE_WIDTH'(mag_pair.flow_horizontal);
      lane_value[1] = VALUE_WIDTH'(mag_pair.flow_vertical);
      lane_value[2] = $signed({{(VALUE_WIDTH - MAG_WIDTH){1'b0}}, mag_root});
   end

   fvq_quant u_quant (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (mag_valid),
      .in_value    (lane_value),
      .lower_bound (lower_bound_ff),
      .upper_bound (upper_bound_ff),
      .out_valid   (quant_valid),
      .out_byte    (lane_byte)
   );

   always_comb begin
      quant_payload.red_byte   = lane_byte[0];
      quant_payload.green_byte = lane_byte[1];
      quant_payload.blue_byte  = lane_byte[2];
   end

   // Output register and skid entry toward the response channel.
   fvq_skid u_skid (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (quant_valid),
      .in_payload  (quant_payload),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
